FILE: sv/text_console_cell_writer_assert.svh
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// Concurrent check on the rising clock, held off while reset is asserted.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the first condition holds, the second must hold in the next cycle.
`define TCW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int SCREENS_DEF = 4;

  localparam int TAB_STOP = 4;

  localparam logic [7:0]  DEF_COLOR  = 8'h07;
  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_TAB     = 8'd9;
  localparam logic [7:0]  CH_BACK    = 8'd8;
  localparam logic [7:0]  CH_SPACE   = 8'd32;
  localparam logic [15:0] RESET_CELL = {DEF_COLOR, CH_SPACE};

  typedef enum logic [2:0] {
    MODE_PUT    = 3'd0,
    MODE_SWITCH = 3'd1,
    MODE_COLOR  = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_CURSOR  = 2'd0,
    KIND_CELL    = 2'd1,
    KIND_REPAINT = 2'd2,
    KIND_READ    = 2'd3
  } kind_e;

endpackage

FILE: sv/tcw_mem.sv
module tcw_mem #(
  parameter int AW = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [2**AW];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/text_console_cell_writer.sv
// Text console cell writer. All screens live in one synchronous cell memory; each screen's
// cursor and color sit in small register files. After reset the block sweeps the whole cell
// memory to blank cells, one entry per cycle (SCREENS rounded up to a power of two, at least
// two, times ROWS*COLUMNS rounded up to a power of two, 8192 entries by default), and takes no
// item meanwhile. A printable byte passes through the EXEC, PUT and EMIT states before its
// result is registered, each tab space through PUT and EMIT once more, and a read through EXEC,
// RDWAIT and EMIT. A scroll copies the screen up one cell per cycle through the memory's read
// and write ports and then blanks the bottom row; a clear writes ROWS*COLUMNS cells. One item
// is handled at a time; a result waits in the output register while the next item is taken.
module text_console_cell_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  parameter int SCREENS = tcw_pkg::SCREENS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  char_code_i,
  input  logic [3:0]  screen_select_i,
  input  logic [3:0]  fore_color_i,
  input  logic [3:0]  back_color_i,
  input  logic [10:0] read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [10:0] cell_position_o,
  output logic [15:0] cell_value_o,
  output logic [4:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o,
  output logic [1:0]  active_screen_o,
  output logic        last_o
);

  `include "text_console_cell_writer_assert.svh"

  localparam int CELLS = ROWS * COLUMNS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = $clog2(CELLS);
  localparam int SW    = (SCREENS > 1) ? $clog2(SCREENS) : 1;
  localparam int AW    = SW + PW;

  localparam logic [PW-1:0] SCROLL_END = PW'(CELLS - COLUMNS);
  localparam logic [PW-1:0] LAST_CELL  = PW'(CELLS - 1);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_INIT   = 10'b0000000010,
    ST_EXEC   = 10'b0000000100,
    ST_PUT    = 10'b0000001000,
    ST_BSWR   = 10'b0000010000,
    ST_SCROLL = 10'b0000100000,
    ST_SFILL  = 10'b0001000000,
    ST_CLEAR  = 10'b0010000000,
    ST_RDWAIT = 10'b0100000000,
    ST_EMIT   = 10'b1000000000
  } state_e;

  state_e state_q, after_q;

  logic [RW-1:0] row_q   [SCREENS];
  logic [CW-1:0] col_q   [SCREENS];
  logic [7:0]    color_q [SCREENS];
  logic [SW-1:0] shown_q;
  logic [7:0]    def_color_q;

  logic [2:0]    mode_q;
  logic [7:0]    ch_q;
  logic [3:0]    sel_q;
  logic [3:0]    fg_q;
  logic [3:0]    bg_q;
  logic [10:0]   idx_q;
  logic [2:0]    tab_left_q;
  logic [AW-1:0] ptr_q;
  logic [PW-1:0] wr_ptr_q;
  logic          rd_pend_q;

  logic [1:0]    pend_kind_q;
  logic [10:0]   pend_pos_q;
  logic [15:0]   pend_val_q;
  logic          pend_last_q;

  logic          out_valid_q;
  logic [1:0]    kind_q;
  logic [10:0]   pos_q;
  logic [15:0]   val_q;
  logic [4:0]    orow_q;
  logic [6:0]    ocol_q;
  logic [1:0]    oscr_q;
  logic          olast_q;

  logic [RW-1:0] row_cur;
  logic [CW-1:0] col_cur;
  logic [7:0]    color_cur;
  logic [PW-1:0] cur_pos;
  logic [PW-1:0] ptr_lo;
  logic [15:0]   blank_cell;
  logic          out_free;
  logic          idx_ok;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  assign row_cur    = row_q[shown_q];
  assign col_cur    = col_q[shown_q];
  assign color_cur  = color_q[shown_q];
  assign cur_pos    = PW'(int'(row_cur) * COLUMNS) + PW'(col_cur);
  assign ptr_lo     = ptr_q[PW-1:0];
  assign blank_cell = {color_cur, tcw_pkg::CH_SPACE};
  assign out_free   = !out_valid_q || !out_stall_i;
  assign idx_ok     = int'(idx_q) < CELLS;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {shown_q, ptr_lo};
    mem_wdata = blank_cell;
    mem_re    = 1'b0;
    mem_raddr = {shown_q, PW'(ptr_lo + PW'(COLUMNS))};
    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = tcw_pkg::RESET_CELL;
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = {shown_q, cur_pos};
        mem_wdata = {color_cur, ch_q};
      end
      ST_BSWR: begin
        mem_we    = 1'b1;
        mem_waddr = {shown_q, cur_pos};
      end
      ST_SCROLL: begin
        mem_we    = rd_pend_q;
        mem_waddr = {shown_q, wr_ptr_q};
        mem_wdata = mem_rdata;
        mem_re    = ptr_lo != SCROLL_END;
      end
      ST_SFILL, ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_EXEC: begin
        mem_re    = (mode_q == tcw_pkg::MODE_READ) && idx_ok;
        mem_raddr = {shown_q, PW'(idx_q)};
      end
      default: begin
      end
    endcase
  end

  tcw_mem #(
    .AW(AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      after_q     <= ST_IDLE;
      for (int s = 0; s < SCREENS; s++) begin
        row_q[s]   <= '0;
        col_q[s]   <= '0;
        color_q[s] <= tcw_pkg::DEF_COLOR;
      end
      shown_q     <= '0;
      def_color_q <= tcw_pkg::DEF_COLOR;
      tab_left_q  <= '0;
      ptr_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        def_color_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      rd_pend_q <= (state_q == ST_SCROLL) && (ptr_lo != SCROLL_END);
      unique case (state_q)
        ST_INIT: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_i;
            ch_q    <= char_code_i;
            sel_q   <= screen_select_i;
            fg_q    <= fore_color_i;
            bg_q    <= back_color_i;
            idx_q   <= read_index_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          pend_val_q  <= '0;
          pend_last_q <= 1'b1;
          after_q     <= ST_IDLE;
          ptr_q       <= '0;
          unique case (mode_q)
            tcw_pkg::MODE_PUT: begin
              pend_kind_q <= tcw_pkg::KIND_CURSOR;
              pend_pos_q  <= '0;
              if (ch_q == tcw_pkg::CH_NEWLINE) begin
                col_q[shown_q] <= '0;
                tab_left_q     <= '0;
                if (row_cur == LAST_ROW) begin
                  state_q <= ST_SCROLL;
                end else begin
                  row_q[shown_q] <= row_cur + 1'b1;
                  state_q        <= ST_EMIT;
                end
              end else if (ch_q == tcw_pkg::CH_TAB) begin
                ch_q       <= tcw_pkg::CH_SPACE;
                tab_left_q <= 3'(tcw_pkg::TAB_STOP - int'(col_cur % tcw_pkg::TAB_STOP));
                state_q    <= ST_PUT;
              end else if (ch_q == tcw_pkg::CH_BACK) begin
                if (col_cur != '0) begin
                  col_q[shown_q] <= col_cur - 1'b1;
                end else if (row_cur != '0) begin
                  row_q[shown_q] <= row_cur - 1'b1;
                  col_q[shown_q] <= LAST_COL;
                end
                state_q <= ST_BSWR;
              end else begin
                tab_left_q <= 3'd1;
                state_q    <= ST_PUT;
              end
            end
            tcw_pkg::MODE_SWITCH: begin
              pend_pos_q <= '0;
              state_q    <= ST_EMIT;
              if (int'(sel_q) < SCREENS && sel_q != 4'(shown_q)) begin
                shown_q     <= SW'(sel_q);
                pend_kind_q <= tcw_pkg::KIND_REPAINT;
              end else begin
                pend_kind_q <= tcw_pkg::KIND_CURSOR;
              end
            end
            tcw_pkg::MODE_COLOR: begin
              color_q[shown_q] <= {bg_q, fg_q};
              pend_kind_q      <= tcw_pkg::KIND_CURSOR;
              pend_pos_q       <= '0;
              state_q          <= ST_EMIT;
            end
            tcw_pkg::MODE_CLEAR: begin
              row_q[shown_q] <= '0;
              col_q[shown_q] <= '0;
              pend_kind_q    <= tcw_pkg::KIND_REPAINT;
              pend_pos_q     <= '0;
              state_q        <= ST_CLEAR;
            end
            tcw_pkg::MODE_READ: begin
              pend_kind_q <= tcw_pkg::KIND_READ;
              pend_pos_q  <= idx_q;
              state_q     <= idx_ok ? ST_RDWAIT : ST_EMIT;
            end
            default: begin
              pend_kind_q <= tcw_pkg::KIND_CURSOR;
              pend_pos_q  <= '0;
              state_q     <= ST_EMIT;
            end
          endcase
        end
        ST_PUT: begin
          pend_kind_q <= tcw_pkg::KIND_CELL;
          pend_pos_q  <= 11'(cur_pos);
          pend_val_q  <= {color_cur, ch_q};
          tab_left_q  <= tab_left_q - 1'b1;
          ptr_q       <= '0;
          state_q     <= ST_EMIT;
          if (col_cur == LAST_COL) begin
            col_q[shown_q] <= '0;
            if (row_cur == LAST_ROW) begin
              pend_last_q <= 1'b0;
              after_q     <= ST_SCROLL;
            end else begin
              row_q[shown_q] <= row_cur + 1'b1;
              pend_last_q    <= tab_left_q == 3'd1;
              after_q        <= (tab_left_q == 3'd1) ? ST_IDLE : ST_PUT;
            end
          end else begin
            col_q[shown_q] <= col_cur + 1'b1;
            pend_last_q    <= tab_left_q == 3'd1;
            after_q        <= (tab_left_q == 3'd1) ? ST_IDLE : ST_PUT;
          end
        end
        ST_BSWR: begin
          pend_kind_q <= tcw_pkg::KIND_CELL;
          pend_pos_q  <= 11'(cur_pos);
          pend_val_q  <= blank_cell;
          pend_last_q <= 1'b1;
          after_q     <= ST_IDLE;
          state_q     <= ST_EMIT;
        end
        ST_SCROLL: begin
          if (ptr_lo != SCROLL_END) begin
            wr_ptr_q <= ptr_lo;
            ptr_q    <= ptr_q + 1'b1;
          end else begin
            state_q <= ST_SFILL;
          end
        end
        ST_SFILL: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_lo == LAST_CELL) begin
            pend_kind_q <= tcw_pkg::KIND_REPAINT;
            pend_pos_q  <= '0;
            pend_val_q  <= '0;
            pend_last_q <= tab_left_q == '0;
            after_q     <= (tab_left_q == '0) ? ST_IDLE : ST_PUT;
            state_q     <= ST_EMIT;
          end
        end
        ST_CLEAR: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_lo == LAST_CELL) begin
            pend_kind_q <= tcw_pkg::KIND_REPAINT;
            state_q     <= ST_EMIT;
          end
        end
        ST_RDWAIT: begin
          pend_val_q <= mem_rdata;
          state_q    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= pend_kind_q;
            pos_q       <= pend_pos_q;
            val_q       <= pend_val_q;
            orow_q      <= 5'(row_cur);
            ocol_q      <= 7'(col_cur);
            oscr_q      <= 2'(shown_q);
            olast_q     <= pend_last_q;
            state_q     <= after_q;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o      = state_q != ST_IDLE;
  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign cell_position_o = pos_q;
  assign cell_value_o    = val_q;
  assign cursor_row_o    = orow_q;
  assign cursor_col_o    = ocol_q;
  assign active_screen_o = oscr_q;
  assign last_o          = olast_q;

  `TCW_ASSERT(a_row_range, int'(row_cur) < ROWS, "Cursor row left the screen.")
  `TCW_ASSERT(a_col_range, int'(col_cur) < COLUMNS, "Cursor column left the screen.")
  `TCW_ASSERT(a_put_count, (state_q == ST_PUT) |-> (tab_left_q != '0), "Put without a count.")
  `TCW_ASSERT(a_copy_scroll, rd_pend_q |-> (state_q == ST_SCROLL), "Copy outside a scroll.")
  `TCW_ASSERT_NEXT(a_accept_exec, in_valid_i && !in_stall_o, state_q == ST_EXEC, "Item lost.")

endmodule
